@@ src/rqc_pkg.sv @@
package rqc_pkg;

   localparam int NUM_COUNTERS_DEF = 4;
   localparam int DATA_W           = 32;
   localparam int CSR_IDX_W        = 3;
   // Width of a 32-bit value scaled by a percentage up to 100
   localparam int PROD_W           = DATA_W + 7;

   localparam int PCT_FULL     = 100;
   localparam int PCT_CRITICAL = 95;
   localparam int PCT_HIGH     = 80;
   localparam int PCT_MODERATE = 60;

   localparam logic [1:0] OP_ACQUIRE = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_PROBE   = 2'd2;
   localparam logic [1:0] OP_CLEAR   = 2'd3;

   localparam logic [1:0] STAT_DONE     = 2'd0;
   localparam logic [1:0] STAT_REFUSED  = 2'd1;
   localparam logic [1:0] STAT_INACTIVE = 2'd2;

   localparam logic [2:0] PRESS_NONE     = 3'd0;
   localparam logic [2:0] PRESS_MODERATE = 3'd1;
   localparam logic [2:0] PRESS_HIGH     = 3'd2;
   localparam logic [2:0] PRESS_CRITICAL = 3'd3;
   localparam logic [2:0] PRESS_EXCEEDED = 3'd4;

   // Limit registers sit at indexes 0 .. NUM_COUNTERS-1
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_MASK = 3'd4;

   typedef struct packed {
      logic [DATA_W-1:0] level;
      logic [DATA_W-1:0] peak;
      logic [DATA_W-1:0] granted;
      logic [DATA_W-1:0] returned;
      logic [DATA_W-1:0] refused;
   } rqc_entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_SCALE,
      ST_CLASS
   } rqc_state_type;

endpackage

@@ src/rqc_ram.sv @@
module rqc_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 4,
   parameter int ADDR_W = 2
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/resource_quota_counters_top.sv @@
// Quota counter table: one counter per resource, each with a limit and an
// active bit set over the csr_ write channel (indexes 0..3 limits, 4 the
// active mask). csr_ready is always high; write only while the block is idle.
//
// Request channel req_ (valid/stall) carries op, counter_index and amount.
// Response channel rsp_ (valid/stall) returns one transaction per request:
// status, level, headroom, pressure class, fit flag and the counter totals.
//
// Each request passes through ST_CALC, ST_SCALE and ST_CLASS from acceptance
// to a loaded response register: the entry is read from the state RAM at
// acceptance, updated and written back in ST_CALC, scaled by the percentages
// in ST_SCALE, and the pressure compares and the response load take ST_CLASS.
// A new request is accepted only after the previous one leaves ST_CLASS;
// req_stall is high while one is in flight. The response register holds its
// transaction while rsp_stall is high, and the next request is taken meanwhile;
// it then waits in the final step until the register frees up.
//
// Synchronous reset clears limits, the active mask, all counters (through
// per-entry valid bits, no clearing pass) and the global refused total.
module resource_quota_counters_top
   import rqc_pkg::*;
#(
   parameter int NUM_COUNTERS = NUM_COUNTERS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_data,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_op,
   input  logic [1:0]           req_counter_index,
   input  logic [DATA_W-1:0]    req_amount,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic [DATA_W-1:0]    rsp_level_now,
   output logic [DATA_W-1:0]    rsp_headroom,
   output logic [2:0]           rsp_pressure,
   output logic                 rsp_fits,
   output logic [DATA_W-1:0]    rsp_peak_seen,
   output logic [DATA_W-1:0]    rsp_granted_sum,
   output logic [DATA_W-1:0]    rsp_returned_sum,
   output logic [DATA_W-1:0]    rsp_refused_sum,
   output logic [DATA_W-1:0]    rsp_refused_all
);

   localparam int IDX_W   = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;
   localparam int ENTRY_W = $bits(rqc_entry_type);

   rqc_state_type state_ff, state_in;

   logic [DATA_W-1:0]       limit_ff [NUM_COUNTERS];
   logic [NUM_COUNTERS-1:0] active_ff;
   logic [NUM_COUNTERS-1:0] vld_ff, vld_in;
   logic [DATA_W-1:0]       total_ff, total_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // request latched at acceptance
   logic [1:0]        op_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [DATA_W-1:0] amt_ff;
   logic              inact_ff;
   logic [DATA_W-1:0] lim_ff;

   // result of the update step
   rqc_entry_type     ent_ff, ent_in;
   logic [1:0]        stat_ff, stat_in;
   logic              fits_ff, fits_in;
   logic [DATA_W-1:0] all_ff;

   // scaling step
   logic [PROD_W-1:0] lvl_x100_ff, lim_x95_ff, lim_x80_ff, lim_x60_ff;
   logic [DATA_W-1:0] head_ff;
   logic              lim_zero_ff;

   logic [2:0]        press_in;

   // control outputs of the sequencer
   logic accept, load_out, ram_wr_en;

   logic              inact_in;
   rqc_entry_type     rd_ent, ram_rd_data;
   logic [DATA_W:0]   sum_wide;
   logic [DATA_W-1:0] lvl_new;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && !req_stall;

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC:  state_in = ST_SCALE;
         ST_SCALE: state_in = ST_CLASS;
         ST_CLASS: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      ram_wr_en = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         ST_IDLE:  req_stall = 1'b0;
         ST_CALC:  ram_wr_en = !inact_ff;
         ST_SCALE: ;
         ST_CLASS: load_out  = !rsp_valid_ff || !rsp_stall;
         default:  ;
      endcase
   end

   // ---------------- state RAM ----------------
   rqc_ram #(
      .WIDTH  (ENTRY_W),
      .DEPTH  (NUM_COUNTERS),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (idx_ff),
      .wr_data (ent_in),
      .rd_en   (accept),
      .rd_addr (req_counter_index[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // Entries never written since reset read as zero. The write in ST_CALC
   // lands before the next request can be accepted, so no forwarding.
   assign rd_ent = vld_ff[idx_ff] ? ram_rd_data : '0;

   assign inact_in = ({1'b0, req_counter_index} >= 3'(NUM_COUNTERS)) ||
                     !active_ff[req_counter_index[IDX_W-1:0]];

   // ---------------- update step ----------------
   always_comb begin
      ent_in   = rd_ent;
      total_in = total_ff;
      stat_in  = STAT_DONE;
      sum_wide = {1'b0, rd_ent.level} + {1'b0, amt_ff};
      fits_in  = sum_wide <= {1'b0, lim_ff};
      lvl_new  = (amt_ff > rd_ent.level) ? '0 : rd_ent.level - amt_ff;
      case (op_ff)
         OP_ACQUIRE: begin
            if (fits_in) begin
               ent_in.level   = sum_wide[DATA_W-1:0];
               ent_in.granted = rd_ent.granted + amt_ff;
               if (sum_wide[DATA_W-1:0] > rd_ent.peak) begin
                  ent_in.peak = sum_wide[DATA_W-1:0];
               end
            end else begin
               ent_in.refused = rd_ent.refused + amt_ff;
               total_in       = total_ff + amt_ff;
               stat_in        = STAT_REFUSED;
            end
         end
         OP_RELEASE: begin
            ent_in.level    = lvl_new;
            ent_in.returned = rd_ent.returned + amt_ff;
         end
         OP_PROBE: ;
         OP_CLEAR: ent_in = '0;
         default:  ;
      endcase
      if (inact_ff) begin
         ent_in   = '0;
         total_in = total_ff;
         stat_in  = STAT_INACTIVE;
         fits_in  = 1'b0;
      end
   end

   always_comb begin
      vld_in = vld_ff;
      if (ram_wr_en) begin
         vld_in[idx_ff] = 1'b1;
      end
   end

   // ---------------- pressure class ----------------
   always_comb begin
      if (lim_zero_ff) begin
         press_in = PRESS_NONE;
      end else if (ent_ff.level >= lim_ff) begin
         press_in = PRESS_EXCEEDED;
      end else if (lvl_x100_ff >= lim_x95_ff) begin
         press_in = PRESS_CRITICAL;
      end else if (lvl_x100_ff >= lim_x80_ff) begin
         press_in = PRESS_HIGH;
      end else if (lvl_x100_ff >= lim_x60_ff) begin
         press_in = PRESS_MODERATE;
      end else begin
         press_in = PRESS_NONE;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         vld_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_COUNTERS; i++) begin
            limit_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_CALC) begin
            total_ff <= total_in;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ACTIVE_MASK) begin
               active_ff <= csr_data[NUM_COUNTERS-1:0];
            end else if (csr_index < 3'(NUM_COUNTERS)) begin
               limit_ff[csr_index[IDX_W-1:0]] <= csr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_op;
         idx_ff   <= req_counter_index[IDX_W-1:0];
         amt_ff   <= req_amount;
         inact_ff <= inact_in;
         lim_ff   <= inact_in ? '0 : limit_ff[req_counter_index[IDX_W-1:0]];
      end
      if (state_ff == ST_CALC) begin
         ent_ff  <= ent_in;
         stat_ff <= stat_in;
         fits_ff <= fits_in;
         all_ff  <= inact_ff ? '0 : total_in;
      end
      if (state_ff == ST_SCALE) begin
         lvl_x100_ff <= PROD_W'(ent_ff.level) * PROD_W'(PCT_FULL);
         lim_x95_ff  <= PROD_W'(lim_ff) * PROD_W'(PCT_CRITICAL);
         lim_x80_ff  <= PROD_W'(lim_ff) * PROD_W'(PCT_HIGH);
         lim_x60_ff  <= PROD_W'(lim_ff) * PROD_W'(PCT_MODERATE);
         head_ff     <= (lim_ff > ent_ff.level) ? lim_ff - ent_ff.level : '0;
         lim_zero_ff <= lim_ff == '0;
      end
      if (load_out) begin
         rsp_status       <= stat_ff;
         rsp_level_now    <= ent_ff.level;
         rsp_headroom     <= head_ff;
         rsp_pressure     <= press_in;
         rsp_fits         <= fits_ff;
         rsp_peak_seen    <= ent_ff.peak;
         rsp_granted_sum  <= ent_ff.granted;
         rsp_returned_sum <= ent_ff.returned;
         rsp_refused_sum  <= ent_ff.refused;
         rsp_refused_all  <= all_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   a_accept_to_calc: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == ST_CALC)
      else $error("accepted transaction did not enter the update step");

   a_refused_not_fit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_REFUSED) |-> !rsp_fits)
      else $error("refused acquire reported as fitting");

   a_inactive_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_INACTIVE) |->
         (rsp_level_now == '0 && rsp_headroom == '0 && rsp_pressure == PRESS_NONE))
      else $error("inactive counter response carries nonzero data");

   a_headroom_pressure: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_headroom != '0) |-> rsp_pressure != PRESS_EXCEEDED)
      else $error("exceeded pressure with headroom left");

   a_total_only_in_calc: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_CALC) |=> $stable(total_ff))
      else $error("global refused total changed outside the update step");
`endif

endmodule

@@ verif/tb_resource_quota_counters_top.sv @@
`timescale 1ns / 100ps

module tb_resource_quota_counters_top;
   import rqc_pkg::*;

   localparam int                   NCNT           = NUM_COUNTERS_DEF;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_BASE = 3'd0;

   typedef struct packed {
      logic [1:0]        status;
      logic [DATA_W-1:0] level_now;
      logic [DATA_W-1:0] headroom;
      logic [2:0]        pressure;
      logic              fits;
      logic [DATA_W-1:0] peak_seen;
      logic [DATA_W-1:0] granted_sum;
      logic [DATA_W-1:0] returned_sum;
      logic [DATA_W-1:0] refused_sum;
      logic [DATA_W-1:0] refused_all;
   } quota_result_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DATA_W-1:0]    csr_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [1:0]           req_op = OP_PROBE;
   logic [1:0]           req_counter_index = '0;
   logic [DATA_W-1:0]    req_amount = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [1:0]           rsp_status;
   logic [DATA_W-1:0]    rsp_level_now;
   logic [DATA_W-1:0]    rsp_headroom;
   logic [2:0]           rsp_pressure;
   logic                 rsp_fits;
   logic [DATA_W-1:0]    rsp_peak_seen;
   logic [DATA_W-1:0]    rsp_granted_sum;
   logic [DATA_W-1:0]    rsp_returned_sum;
   logic [DATA_W-1:0]    rsp_refused_sum;
   logic [DATA_W-1:0]    rsp_refused_all;

   // Mirror of the block's registers and counter table
   logic [DATA_W-1:0] cfg_limit [NCNT];
   logic [NCNT-1:0]   cfg_active;
   logic [DATA_W-1:0] cnt_level [NCNT];
   logic [DATA_W-1:0] cnt_peak [NCNT];
   logic [DATA_W-1:0] cnt_granted [NCNT];
   logic [DATA_W-1:0] cnt_returned [NCNT];
   logic [DATA_W-1:0] cnt_refused [NCNT];
   logic [DATA_W-1:0] refused_grand;

   quota_result_t pending_results [$];

   int mismatches = 0;
   int requests_sent = 0;
   int results_seen = 0;
   int refused_seen = 0;
   int inactive_seen = 0;
   int config_settings = 0;

   bit idle_on = 1'b0;
   bit stall_on = 1'b0;
   int hold_left = 0;
   int stall_left = 0;

   resource_quota_counters_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_counter_index (req_counter_index),
      .req_amount        (req_amount),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_level_now     (rsp_level_now),
      .rsp_headroom      (rsp_headroom),
      .rsp_pressure      (rsp_pressure),
      .rsp_fits          (rsp_fits),
      .rsp_peak_seen     (rsp_peak_seen),
      .rsp_granted_sum   (rsp_granted_sum),
      .rsp_returned_sum  (rsp_returned_sum),
      .rsp_refused_sum   (rsp_refused_sum),
      .rsp_refused_all   (rsp_refused_all)
   );

   always #1 clock = ~clock;

   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Mostly short, now and then long
   function automatic int stretch_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [2:0] pressure_of(logic [DATA_W-1:0] level,
                                              logic [DATA_W-1:0] lim);
      longint unsigned scaled;
      longint unsigned base;
      scaled = 64'(level);
      scaled = scaled * PCT_FULL;
      base = 64'(lim);
      if (lim == '0) return PRESS_NONE;
      if (scaled >= base * PCT_FULL) return PRESS_EXCEEDED;
      if (scaled >= base * PCT_CRITICAL) return PRESS_CRITICAL;
      if (scaled >= base * PCT_HIGH) return PRESS_HIGH;
      if (scaled >= base * PCT_MODERATE) return PRESS_MODERATE;
      return PRESS_NONE;
   endfunction

   // Applies one request to the mirrored table and returns the response
   function automatic quota_result_t quota_update(logic [1:0] op, logic [1:0] idx,
                                                  logic [DATA_W-1:0] amt);
      quota_result_t r;
      logic [DATA_W:0] sum;
      logic [DATA_W-1:0] lim;
      r = '0;
      if (!cfg_active[idx]) begin
         r.status = STAT_INACTIVE;
         return r;
      end
      lim = cfg_limit[idx];
      sum = {1'b0, cnt_level[idx]} + {1'b0, amt};
      r.fits = (sum <= {1'b0, lim});
      r.status = STAT_DONE;
      case (op)
         OP_ACQUIRE: begin
            if (r.fits) begin
               cnt_level[idx] = cnt_level[idx] + amt;
               cnt_granted[idx] = cnt_granted[idx] + amt;
               if (cnt_level[idx] > cnt_peak[idx]) cnt_peak[idx] = cnt_level[idx];
            end else begin
               cnt_refused[idx] = cnt_refused[idx] + amt;
               refused_grand = refused_grand + amt;
               r.status = STAT_REFUSED;
            end
         end
         OP_RELEASE: begin
            cnt_level[idx] = (amt > cnt_level[idx]) ? '0 : cnt_level[idx] - amt;
            cnt_returned[idx] = cnt_returned[idx] + amt;
         end
         OP_CLEAR: begin
            cnt_level[idx] = '0;
            cnt_peak[idx] = '0;
            cnt_granted[idx] = '0;
            cnt_returned[idx] = '0;
            cnt_refused[idx] = '0;
         end
         default: ;
      endcase
      r.level_now = cnt_level[idx];
      r.headroom = (lim > cnt_level[idx]) ? lim - cnt_level[idx] : '0;
      r.pressure = pressure_of(cnt_level[idx], lim);
      r.peak_seen = cnt_peak[idx];
      r.granted_sum = cnt_granted[idx];
      r.returned_sum = cnt_returned[idx];
      r.refused_sum = cnt_refused[idx];
      r.refused_all = refused_grand;
      return r;
   endfunction

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      if (idx < CSR_LIMIT_BASE + NCNT) cfg_limit[idx - CSR_LIMIT_BASE] = data;
      else if (idx == CSR_ACTIVE_MASK) cfg_active = data[NCNT-1:0];
      @(posedge clock);
   endtask

   task automatic set_quota_config(logic [DATA_W-1:0] l0, logic [DATA_W-1:0] l1,
                                   logic [DATA_W-1:0] l2, logic [DATA_W-1:0] l3,
                                   logic [DATA_W-1:0] mask);
      csr_write(CSR_LIMIT_BASE + 3'd0, l0);
      csr_write(CSR_LIMIT_BASE + 3'd1, l1);
      csr_write(CSR_LIMIT_BASE + 3'd2, l2);
      csr_write(CSR_LIMIT_BASE + 3'd3, l3);
      csr_write(CSR_ACTIVE_MASK, mask);
      config_settings++;
   endtask

   // Leaves valid high after the accept so a back-to-back transaction can follow
   task automatic send_request(logic [1:0] op, logic [1:0] idx, logic [DATA_W-1:0] amt);
      int gap;
      quota_result_t r;
      gap = (idle_on && $urandom_range(0, 99) < 30) ? stretch_len() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_counter_index <= idx;
      req_amount <= amt;
      do @(posedge clock); while (req_stall !== 1'b0);
      r = quota_update(op, idx, amt);
      if (r.status == STAT_REFUSED) refused_seen++;
      if (r.status == STAT_INACTIVE) inactive_seen++;
      pending_results.push_back(r);
      requests_sent++;
   endtask

   // Block is idle once every response is back; margin covers the pipeline
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [DATA_W-1:0] pick_amount(logic [1:0] op, logic [1:0] idx);
      int r;
      logic [DATA_W-1:0] room;
      r = $urandom_range(0, 99);
      room = (cfg_limit[idx] > cnt_level[idx]) ? cfg_limit[idx] - cnt_level[idx] : '0;
      if (r < 8) return '0;
      if (r < 38) return $urandom_range(0, 64);
      if (r < 60) return $urandom_range(0, room);
      if (r < 72) return (op == OP_RELEASE) ? cnt_level[idx] : room;
      if (r < 80) return room + 1;
      if (r < 93) return $urandom;
      return '1;
   endfunction

   function automatic logic [1:0] pick_op();
      int r;
      r = $urandom_range(0, 99);
      if (r < 42) return OP_ACQUIRE;
      if (r < 68) return OP_RELEASE;
      if (r < 94) return OP_PROBE;
      return OP_CLEAR;
   endfunction

   function automatic logic [DATA_W-1:0] pick_limit();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return '0;
      if (r < 30) return '1;
      if (r < 50) return $urandom_range(1, 200);
      if (r < 75) return $urandom_range(1000, 100000);
      return $urandom;
   endfunction

   task automatic send_random_request();
      logic [1:0] op;
      logic [1:0] idx;
      op = pick_op();
      idx = 2'($urandom_range(0, NCNT - 1));
      send_request(op, idx, pick_amount(op, idx));
   endtask

   task automatic check_field(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s mismatch, expected 0x%08h, got 0x%08h", $realtime, what, want, got);
      end
   endtask

   // Response checker
   always @(posedge clock) begin
      quota_result_t want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response transaction with none outstanding", $realtime);
         end else begin
            want = pending_results.pop_front();
            results_seen++;
            check_field("status", DATA_W'(want.status), DATA_W'(rsp_status));
            check_field("level_now", want.level_now, rsp_level_now);
            check_field("headroom", want.headroom, rsp_headroom);
            check_field("pressure", DATA_W'(want.pressure), DATA_W'(rsp_pressure));
            check_field("fits", DATA_W'(want.fits), DATA_W'(rsp_fits));
            check_field("peak_seen", want.peak_seen, rsp_peak_seen);
            check_field("granted_sum", want.granted_sum, rsp_granted_sum);
            check_field("returned_sum", want.returned_sum, rsp_returned_sum);
            check_field("refused_sum", want.refused_sum, rsp_refused_sum);
            check_field("refused_all", want.refused_all, rsp_refused_all);
         end
      end
   end

   // Response side: long hold-off when requested, otherwise random stalls while stall_on is set
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_on && $urandom_range(0, 99) < 20) begin
         stall_left = stretch_len() - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic test_after_reset();
      // Nothing active yet: each op, sent once to its own counter, reports inactive
      for (int i = 0; i < NCNT; i++) send_request(2'(OP_ACQUIRE + i), 2'(i), 32'h1);
      wait_idle();
   endtask

   task automatic test_directed_corners();
      idle_on = 1'b1;
      stall_on = 1'b1;
      // upper mask bits must be dropped; indexes past the list are ignored
      set_quota_config(32'd100, '1, '0, 32'd1000, 32'hFFFF_FFF7);
      csr_write(CSR_ACTIVE_MASK + 3'd1, '1);
      csr_write(CSR_ACTIVE_MASK + 3'd2, '1);
      csr_write(CSR_ACTIVE_MASK + 3'd3, 32'h5A5A_A5A5);
      // walk the pressure thresholds on a limit of 100
      send_request(OP_ACQUIRE, 2'd0, 32'd59);
      send_request(OP_ACQUIRE, 2'd0, 32'd1);
      send_request(OP_ACQUIRE, 2'd0, 32'd19);
      send_request(OP_ACQUIRE, 2'd0, 32'd1);
      send_request(OP_ACQUIRE, 2'd0, 32'd14);
      send_request(OP_ACQUIRE, 2'd0, 32'd1);
      send_request(OP_ACQUIRE, 2'd0, 32'd5);
      send_request(OP_ACQUIRE, 2'd0, 32'd0);
      send_request(OP_ACQUIRE, 2'd0, 32'd1);
      send_request(OP_PROBE, 2'd0, 32'd1);
      send_request(OP_RELEASE, 2'd0, 32'd150);
      send_request(OP_PROBE, 2'd0, 32'd0);
      // full-scale limit: no wraparound in the fit check
      send_request(OP_ACQUIRE, 2'd1, '1);
      send_request(OP_ACQUIRE, 2'd1, 32'd1);
      send_request(OP_ACQUIRE, 2'd1, '1);
      send_request(OP_RELEASE, 2'd1, '1);
      // zero limit
      send_request(OP_ACQUIRE, 2'd2, 32'd0);
      send_request(OP_ACQUIRE, 2'd2, 32'd1);
      // counter 3 is not active
      send_request(OP_ACQUIRE, 2'd3, 32'd5);
      send_request(OP_RELEASE, 2'd3, 32'd5);
      send_request(OP_PROBE, 2'd3, 32'd5);
      send_request(OP_CLEAR, 2'd3, 32'd5);
      send_request(OP_CLEAR, 2'd0, '1);
      wait_idle();
   endtask

   task automatic test_limit_lowered();
      csr_write(CSR_ACTIVE_MASK, 32'hF);
      send_request(OP_ACQUIRE, 2'd3, 32'd800);
      send_request(OP_ACQUIRE, 2'd0, 32'd42);
      wait_idle();
      csr_write(CSR_LIMIT_BASE + 3'd3, 32'd500);
      send_request(OP_PROBE, 2'd3, 32'd0);
      send_request(OP_ACQUIRE, 2'd3, 32'd0);
      send_request(OP_ACQUIRE, 2'd3, 32'd7);
      send_request(OP_RELEASE, 2'd3, 32'd100);
      wait_idle();
      // deactivating a counter must leave its state alone
      csr_write(CSR_ACTIVE_MASK, 32'hE);
      send_request(OP_PROBE, 2'd0, 32'd0);
      wait_idle();
      csr_write(CSR_ACTIVE_MASK, 32'hF);
      config_settings++;
      send_request(OP_PROBE, 2'd0, 32'd0);
      send_request(OP_CLEAR, 2'd3, 32'd0);
      wait_idle();
   endtask

   task automatic test_output_backpressure();
      idle_on = 1'b0;
      stall_on = 1'b0;
      set_quota_config(32'd5000, 32'd300, '1, 32'd64, 32'hF);
      hold_left = 300;
      repeat (30) send_random_request();
      wait_idle();
   endtask

   task automatic test_sender_pause();
      idle_on = 1'b1;
      stall_on = 1'b1;
      repeat (4) begin
         repeat (10) send_random_request();
         wait_idle();
      end
   endtask

   task automatic test_random_traffic();
      logic [DATA_W-1:0] mask;
      for (int phase = 0; phase < 8; phase++) begin
         idle_on = (phase % 3 != 0);
         stall_on = (phase % 3 != 0);
         mask = ($urandom_range(0, 99) < 70) ? 32'hF : $urandom;
         case (phase)
            0: set_quota_config('1, '1, '1, '1, 32'hF);
            1: set_quota_config('0, '0, '0, '0, 32'hF);
            2: set_quota_config(32'd20, 32'd100, 32'd1, 32'd7, 32'hF);
            default: set_quota_config(pick_limit(), pick_limit(), pick_limit(),
                                      pick_limit(), mask);
         endcase
         repeat (phase == 1 ? 80 : 250) send_random_request();
         wait_idle();
      end
   endtask

   initial begin
      for (int i = 0; i < NCNT; i++) begin
         cfg_limit[i] = '0;
         cnt_level[i] = '0;
         cnt_peak[i] = '0;
         cnt_granted[i] = '0;
         cnt_returned[i] = '0;
         cnt_refused[i] = '0;
      end
      cfg_active = '0;
      refused_grand = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_after_reset();
      test_directed_corners();
      test_limit_lowered();
      test_output_backpressure();
      test_sender_pause();
      test_random_traffic();

      wait_idle();
      repeat (20) @(posedge clock);
      $display("Checked %0d responses to %0d requests over %0d register settings",
               results_seen, requests_sent, config_settings);
      $display("  %0d acquires refused, %0d requests to inactive counters, %0d mismatches",
               refused_seen, inactive_seen, mismatches);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
